>>> rtl/gped_pkg.sv
// Shared types and constants for the gait phase event detector.
// Event codes, register indexes, fired-flag and minimum-tracker bit positions.
// No dependencies.
package gped_pkg;

    // Field widths
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int FRAC_SHIFT  = 12;
    localparam int EVENT_W     = 3;
    localparam int CFG_INDEX_W = 8;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    typedef logic [EVENT_W-1:0]  event_t;
    typedef logic [FRAC_W-1:0]   frac_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Event codes
    localparam event_t EV_NONE = 3'd0;
    localparam event_t EV_HR   = 3'd1;
    localparam event_t EV_TO   = 3'd2;
    localparam event_t EV_FA   = 3'd3;
    localparam event_t EV_TBV  = 3'd4;
    localparam event_t EV_IC   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HR  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TO  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FA  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TBV = 8'd3;

    // Register reset values (Q4.12)
    localparam frac_t HR_FRAC_RST  = 16'd1024;
    localparam frac_t TO_FRAC_RST  = 16'd3072;
    localparam frac_t FA_FRAC_RST  = 16'd1024;
    localparam frac_t TBV_FRAC_RST = 16'd3072;

    // Fired flag bit positions
    localparam int FLG_HR  = 0;
    localparam int FLG_TO  = 1;
    localparam int FLG_FA  = 2;
    localparam int FLG_TBV = 3;

    // Minimum tracker bit positions
    localparam int TRK_NEG  = 0;
    localparam int TRK_DONE = 1;
    localparam int TRK_DOWN = 2;
    localparam logic [2:0] TRK_ENTER = 3'b001;

endpackage

>>> rtl/gait_phase_event_detector.sv
// Gait phase event detector: input register, state update core, result register.
// Depends on gped_pkg, gped_thresh, gped_core and gped_obuf.
//
// Usage:
//   s_* carries one signed 16-bit angular-rate sample per transfer (tdata).
//   m_* returns exactly one event code per sample, in order
//   (0 none, 1 HR, 2 TO, 3 FA, 4 TBV, 5 IC).
//   cfg_we/cfg_index/cfg_wdata write the four Q4.12 threshold fractions
//   (index 0 HR, 1 TO, 2 FA, 3 TBV); other indexes are dropped. Write only
//   while no sample is in flight.
// Path: an accepted sample passes the input register, then the result
//   register, before its event code shows on m_*.
// Throughput: one sample per cycle while m_tready stays high. A totals latch
//   at a negative-to-positive crossing or a register write refreshes the
//   threshold products; the next sample waits in the input register meanwhile.
// Reset (aresetn low, synchronous): sums, totals, flags and tracker clear,
//   fractions return to their defaults, both channels empty.
// Receiver stall: the result register holds its code; the input register
//   still takes one more sample, then s_tready drops until m_tready returns.
module gait_phase_event_detector #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [gped_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample
    // result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gped_pkg::M_TDATA_W-1:0]      m_tdata,   // [2:0] event_code
    // configuration
    input  logic                                cfg_we,
    input  logic [gped_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gped_pkg::FRAC_W-1:0]         cfg_wdata
);

    localparam int PW = SUM_WIDTH + gped_pkg::FRAC_W;

    logic              in_valid_reg;
    gped_pkg::sample_t in_sample_reg;
    logic              fire;
    logic              out_free;
    logic              prod_valid;
    logic              latch;
    logic [PW-1:0]     prod_hr, prod_to, prod_fa, prod_tbv;
    logic [SUM_WIDTH-1:0] last_pos, last_neg;
    gped_pkg::event_t  event_code;

    // Process the held sample when products are fresh and the result slot is free
    assign fire     = in_valid_reg && prod_valid && out_free;
    assign s_tready = !in_valid_reg || fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata;
        end
    end

    gped_thresh #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_thresh (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .latch      (latch),
        .last_pos   (last_pos),
        .last_neg   (last_neg),
        .prod_hr    (prod_hr),
        .prod_to    (prod_to),
        .prod_fa    (prod_fa),
        .prod_tbv   (prod_tbv),
        .prod_valid (prod_valid)
    );

    gped_core #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .sample     (in_sample_reg),
        .prod_hr    (prod_hr),
        .prod_to    (prod_to),
        .prod_fa    (prod_fa),
        .prod_tbv   (prod_tbv),
        .last_pos   (last_pos),
        .last_neg   (last_neg),
        .event_code (event_code),
        .latch      (latch)
    );

    gped_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .code     (event_code),
        .can_take (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> rtl/gped_thresh.sv
// Threshold fraction registers and the four fraction-times-total products.
// Depends on gped_pkg; totals come from gped_core.
// Products are recomputed every cycle; prod_valid drops after a latch or a cfg write.
module gped_thresh #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [gped_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gped_pkg::FRAC_W-1:0]          cfg_wdata,
    input  logic                                 latch,
    input  logic [SUM_WIDTH-1:0]                 last_pos,
    input  logic [SUM_WIDTH-1:0]                 last_neg,
    output logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_hr,
    output logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_to,
    output logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_fa,
    output logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_tbv,
    output logic                                 prod_valid
);

    localparam int PW = SUM_WIDTH + gped_pkg::FRAC_W;

    gped_pkg::frac_t hr_frac_reg, to_frac_reg, fa_frac_reg, tbv_frac_reg;
    logic [PW-1:0]   prod_hr_reg, prod_to_reg, prod_fa_reg, prod_tbv_reg;
    logic            prod_valid_reg;

    // Register writes; other indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hr_frac_reg  <= gped_pkg::HR_FRAC_RST;
            to_frac_reg  <= gped_pkg::TO_FRAC_RST;
            fa_frac_reg  <= gped_pkg::FA_FRAC_RST;
            tbv_frac_reg <= gped_pkg::TBV_FRAC_RST;
        end else if (cfg_we) begin
            if (cfg_index == gped_pkg::REG_HR)  hr_frac_reg  <= cfg_wdata;
            if (cfg_index == gped_pkg::REG_TO)  to_frac_reg  <= cfg_wdata;
            if (cfg_index == gped_pkg::REG_FA)  fa_frac_reg  <= cfg_wdata;
            if (cfg_index == gped_pkg::REG_TBV) tbv_frac_reg <= cfg_wdata;
        end
    end

    // Threshold products, one multiplier each
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_hr_reg  <= '0;
            prod_to_reg  <= '0;
            prod_fa_reg  <= '0;
            prod_tbv_reg <= '0;
        end else begin
            prod_hr_reg  <= PW'(hr_frac_reg)  * PW'(last_neg);
            prod_to_reg  <= PW'(to_frac_reg)  * PW'(last_neg);
            prod_fa_reg  <= PW'(fa_frac_reg)  * PW'(last_pos);
            prod_tbv_reg <= PW'(tbv_frac_reg) * PW'(last_pos);
        end
    end

    // Products are flagged stale in the cycle after a totals latch or a register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b1;
        end else begin
            prod_valid_reg <= !(latch || cfg_we);
        end
    end

    assign prod_hr    = prod_hr_reg;
    assign prod_to    = prod_to_reg;
    assign prod_fa    = prod_fa_reg;
    assign prod_tbv   = prod_tbv_reg;
    assign prod_valid = prod_valid_reg;

endmodule

>>> rtl/gped_core.sv
// Per-sample state update: saturating phase sums, threshold events and IC detection.
// Depends on gped_pkg; products come from gped_thresh.
// All state advances in the cycle in which fire is high.
module gped_core #(
    parameter int SUM_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  fire,
    input  gped_pkg::sample_t                     sample,
    input  logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_hr,
    input  logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_to,
    input  logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_fa,
    input  logic [SUM_WIDTH+gped_pkg::FRAC_W-1:0] prod_tbv,
    output logic [SUM_WIDTH-1:0]                  last_pos,
    output logic [SUM_WIDTH-1:0]                  last_neg,
    output gped_pkg::event_t                      event_code,
    output logic                                  latch
);

    localparam int PW = SUM_WIDTH + gped_pkg::FRAC_W;

    logic [SUM_WIDTH-1:0] pos_sum_reg, pos_sum_next;
    logic [SUM_WIDTH-1:0] neg_sum_reg, neg_sum_next;
    logic [SUM_WIDTH-1:0] last_pos_reg, last_pos_next;
    logic [SUM_WIDTH-1:0] last_neg_reg, last_neg_next;
    logic [3:0]           flags_reg, flags_next;
    gped_pkg::sample_t    prev_reg, prev_next;
    logic                 have_prev_reg, have_prev_next;
    logic [2:0]           trk_reg, trk_next;
    logic                 was_pos_reg, was_pos_next;

    logic                 pos;
    logic [16:0]          mag;
    logic [SUM_WIDTH:0]   pos_add, neg_add;
    logic [SUM_WIDTH-1:0] pos_sat, neg_sat, side_sum;
    logic [PW-1:0]        side_scaled;
    logic                 tot_nz, hit_a, hit_b;
    logic [2:0]           trk_a, trk_b, trk_c;
    logic                 ic_active, down, ic_hit;
    gped_pkg::event_t     code;
    logic                 boundary;

    // Sample sign and magnitude; minus full scale gives 32768 exactly
    assign pos = sample > 16'sd0;
    assign mag = pos ? {1'b0, sample} : 17'd0 - {sample[15], sample};

    // Saturating sums
    assign pos_add = {1'b0, pos_sum_reg} + (SUM_WIDTH+1)'(mag);
    assign neg_add = {1'b0, neg_sum_reg} + (SUM_WIDTH+1)'(mag);
    assign pos_sat = pos_add[SUM_WIDTH] ? '1 : pos_add[SUM_WIDTH-1:0];
    assign neg_sat = neg_add[SUM_WIDTH] ? '1 : neg_add[SUM_WIDTH-1:0];

    // Threshold compares on the side of this sample
    assign side_sum    = pos ? pos_sat : neg_sat;
    assign side_scaled = PW'({side_sum, {gped_pkg::FRAC_SHIFT{1'b0}}});
    assign tot_nz      = pos ? (|last_pos_reg) : (|last_neg_reg);
    assign hit_a = tot_nz
                 && !(pos ? flags_reg[gped_pkg::FLG_FA] : flags_reg[gped_pkg::FLG_HR])
                 && (side_scaled >= (pos ? prod_fa : prod_hr));
    assign hit_b = tot_nz
                 && !(pos ? flags_reg[gped_pkg::FLG_TBV] : flags_reg[gped_pkg::FLG_TO])
                 && (side_scaled >= (pos ? prod_tbv : prod_to));

    // Minimum tracker
    always_comb begin
        trk_a = trk_reg;
        if (!trk_reg[gped_pkg::TRK_NEG] && sample < 16'sd0) begin
            trk_a = gped_pkg::TRK_ENTER;
        end
        ic_active = trk_a[gped_pkg::TRK_NEG] && !trk_a[gped_pkg::TRK_DONE];
        down      = sample < prev_reg;
        ic_hit    = ic_active && trk_a[gped_pkg::TRK_DOWN] && !down;
        trk_b = trk_a;
        if (ic_active) begin
            trk_b[gped_pkg::TRK_DOWN] = down;
        end
        trk_c = trk_b;
        if (pos) begin
            trk_c[gped_pkg::TRK_NEG] = 1'b0;
        end
    end

    // Next state in event priority order
    always_comb begin
        pos_sum_next   = pos ? pos_sat : pos_sum_reg;
        neg_sum_next   = pos ? neg_sum_reg : neg_sat;
        last_pos_next  = last_pos_reg;
        last_neg_next  = last_neg_reg;
        flags_next     = flags_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        trk_next       = trk_reg;
        was_pos_next   = was_pos_reg;
        code           = gped_pkg::EV_NONE;
        boundary       = 1'b0;
        priority if (hit_a) begin
            if (pos) begin
                flags_next[gped_pkg::FLG_FA] = 1'b1;
                code = gped_pkg::EV_FA;
            end else begin
                flags_next[gped_pkg::FLG_HR] = 1'b1;
                code = gped_pkg::EV_HR;
            end
        end else if (hit_b) begin
            if (pos) begin
                flags_next[gped_pkg::FLG_TBV] = 1'b1;
                code = gped_pkg::EV_TBV;
            end else begin
                flags_next[gped_pkg::FLG_TO] = 1'b1;
                code = gped_pkg::EV_TO;
            end
        end else if (!have_prev_reg) begin
            have_prev_next = 1'b1;
            prev_next      = sample;
        end else if (ic_hit) begin
            trk_next = trk_a;
            trk_next[gped_pkg::TRK_DONE] = 1'b1;
            prev_next = sample;
            code      = gped_pkg::EV_IC;
        end else begin
            trk_next = trk_c;
            // Negative-to-positive crossing: latch totals, clear sums and flags
            if (!was_pos_reg && pos) begin
                boundary      = 1'b1;
                last_pos_next = pos_sat;
                last_neg_next = neg_sum_reg;
                pos_sum_next  = '0;
                neg_sum_next  = '0;
                flags_next    = '0;
            end
            was_pos_next = pos;
            prev_next    = sample;
        end
    end

    // State registers, advanced once per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_sum_reg   <= '0;
            neg_sum_reg   <= '0;
            last_pos_reg  <= '0;
            last_neg_reg  <= '0;
            flags_reg     <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            trk_reg       <= '0;
            was_pos_reg   <= 1'b1;
        end else if (fire) begin
            pos_sum_reg   <= pos_sum_next;
            neg_sum_reg   <= neg_sum_next;
            last_pos_reg  <= last_pos_next;
            last_neg_reg  <= last_neg_next;
            flags_reg     <= flags_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            trk_reg       <= trk_next;
            was_pos_reg   <= was_pos_next;
        end
    end

    assign last_pos   = last_pos_reg;
    assign last_neg   = last_neg_reg;
    assign event_code = code;
    assign latch      = fire && boundary;

endmodule

>>> rtl/gped_obuf.sv
// Result register for the event code channel.
// Depends on gped_pkg.
// Holds one result until the receiver takes it; frees itself in the same cycle.
module gped_obuf (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  gped_pkg::event_t                 code,
    output logic                             can_take,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [gped_pkg::M_TDATA_W-1:0]   m_tdata   // [2:0] event_code
);

    logic             valid_reg;
    gped_pkg::event_t code_reg;

    assign can_take = !valid_reg || m_tready;

    // Hold the result until transfer, load a new one when free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_take) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_take) begin
            code_reg <= code;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = gped_pkg::M_TDATA_W'(code_reg);

endmodule
